FILE: sv/start_byte_xor_frame_receiver_core_defines.svh
// assertion macros used by the checker file
`ifndef START_BYTE_XOR_FRAME_RECEIVER_CORE_DEFINES_SVH
`define START_BYTE_XOR_FRAME_RECEIVER_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define SBX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define SBX_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sbx_pkg.sv
package sbx_pkg;

  localparam logic [7:0] START_BYTE_RESET     = 8'hAA;
  localparam logic [5:0] PAYLOAD_LENGTH_RESET = 6'd20;
  localparam int unsigned MAX_RESULTS         = 32;

  // configuration register indexes
  localparam logic [7:0] REG_START_BYTE     = 8'd0;
  localparam logic [7:0] REG_PAYLOAD_LENGTH = 8'd1;

  // controller to datapath commands
  typedef struct packed {
    logic frame_start;
    logic store;
    logic emit_start;
    logic rd_issue;
    logic out_load;
    logic emit_adv;
  } sbx_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start_match;
    logic len_done;
    logic xor_match;
    logic emit_last;
    logic out_free;
  } sbx_status_t;

endpackage

FILE: sv/start_byte_xor_frame_receiver_core.sv
// Start-byte framed receiver with XOR checksum. Received bytes come in as beats
// on the rx channel; while waiting, every byte but the configured start byte is
// dropped. The next payload_length bytes (0 taken as 1, clamped to PAYLOAD_MAX)
// are stored and XORed, then one checksum byte follows. On a match the stored
// payload goes out as one beat per byte with its position and a last flag; on a
// mismatch nothing comes out. Input beats are taken one per cycle while waiting,
// storing or checking, so a frame of N payload bytes is N+2 input beats.
// A good checksum starts a readout of min(N,32) bytes, each a registered read
// of the payload memory, then a load of the output register once it is free;
// the input is stalled during readout and is taken again as soon as the last
// byte sits in the output register. Configuration writes are always ready and
// belong in idle periods; no clearing pass is needed after reset.
module start_byte_xor_frame_receiver_core #(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  // received bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // validated payload beats
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic [4:0] byte_position,
  output logic       last_byte
);

  sbx_pkg::sbx_cmd_t    cmd;
  sbx_pkg::sbx_status_t status;

  // registers are plain flops, a write can land on any cycle
  assign cfg_ready = 1'b1;

  // sequencing: wait, payload, check, then read/load per output beat
  sbx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // config regs, counters, xor, payload memory and output register
  sbx_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

FILE: sv/sbx_ctrl.sv
module sbx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sbx_pkg::sbx_status_t status,
  output sbx_pkg::sbx_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_WAIT    = 5'b00001,
    ST_PAYLOAD = 5'b00010,
    ST_CHECK   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_LD = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_stall = (state == ST_EMIT_RD) || (state == ST_EMIT_LD);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_WAIT: begin
        if (in_fire && status.start_match) begin
          cmd.frame_start = 1'b1;
          state_next      = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          cmd.store = 1'b1;
          if (status.len_done) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (status.xor_match) begin
            cmd.emit_start = 1'b1;
            state_next     = ST_EMIT_RD;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.emit_last) begin
            state_next = ST_WAIT;
          end else begin
            cmd.emit_adv = 1'b1;
            state_next   = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_WAIT;
    else     state <= state_next;
  end

endmodule

FILE: sv/sbx_dp.sv
module sbx_dp #(
  parameter int PAYLOAD_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           rx_byte,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           payload_byte,
  output logic [4:0]           byte_position,
  output logic                 last_byte,
  input  sbx_pkg::sbx_cmd_t    cmd,
  output sbx_pkg::sbx_status_t status
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int CW = $clog2(PAYLOAD_MAX + 1);
  localparam logic [CW-1:0] PM_C  = CW'(PAYLOAD_MAX);
  localparam logic [6:0]    PM_7  = 7'(PAYLOAD_MAX);
  localparam logic [6:0]    MAX_7 = 7'(sbx_pkg::MAX_RESULTS);

  logic [7:0]    start_byte;
  logic [5:0]    payload_length;
  logic [CW-1:0] byte_count;
  logic [7:0]    running_xor;
  logic [AW-1:0] emit_idx;
  logic [7:0]    rd_data;
  logic [7:0]    mem [PAYLOAD_MAX];

  logic [6:0] len_7;
  logic [6:0] eff_len;
  logic [6:0] cnt_after;
  logic [6:0] cnt_7;
  logic [6:0] run_len;
  logic       room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= sbx_pkg::START_BYTE_RESET;
      payload_length <= sbx_pkg::PAYLOAD_LENGTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == sbx_pkg::REG_START_BYTE) start_byte <= cfg_data;
      else if (cfg_index == sbx_pkg::REG_PAYLOAD_LENGTH) payload_length <= cfg_data[5:0];
    end
  end

  // effective length, clamped to 1..PAYLOAD_MAX
  assign len_7   = 7'(payload_length);
  assign eff_len = (len_7 == 7'd0) ? 7'd1 : ((len_7 > PM_7) ? PM_7 : len_7);
  assign room    = byte_count < PM_C;
  assign cnt_after = 7'(byte_count) + (room ? 7'd1 : 7'd0);
  assign cnt_7   = 7'(byte_count);
  assign run_len = (cnt_7 > MAX_7) ? MAX_7 : cnt_7;

  assign status.start_match = (rx_byte == start_byte);
  assign status.len_done    = (cnt_after >= eff_len);
  assign status.xor_match   = (rx_byte == running_xor);
  assign status.emit_last   = ((7'(emit_idx) + 7'd1) == run_len);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_xor <= '0;
      emit_idx    <= '0;
    end else begin
      if (cmd.frame_start) begin
        byte_count  <= '0;
        running_xor <= '0;
      end else if (cmd.store) begin
        running_xor <= running_xor ^ rx_byte;
        if (room) byte_count <= byte_count + CW'(1);
      end
      if (cmd.emit_start)    emit_idx <= '0;
      else if (cmd.emit_adv) emit_idx <= emit_idx + AW'(1);
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.store && room) mem[byte_count[AW-1:0]] <= rx_byte;
    if (cmd.rd_issue)      rd_data <= mem[emit_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      payload_byte  <= rd_data;
      byte_position <= 5'(emit_idx);
      last_byte     <= status.emit_last;
    end
  end

endmodule

FILE: sv/sbx_checker.sv
`include "start_byte_xor_frame_receiver_core_defines.svh"

module sbx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] payload_byte,
  input logic [4:0] byte_position,
  input logic       last_byte
);

  // stalled output beat holds
  `SBX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(byte_position) && $stable(last_byte), "output beat changed under stall")

  // readout starts only on an accepted checksum byte
  `SBX_ASSERT(a_stall_rise, $rose(in_stall) && !$past(rst) |-> $past(in_valid && !in_stall), "input stalled without a checksum beat")

  // readout ends with the last beat loaded
  `SBX_ASSERT(a_stall_fall, $fell(in_stall) && !$past(rst) |-> out_valid && last_byte, "readout ended without last beat")

  // reset leaves the block empty and ready for input
  `SBX_ASSERT_NR(a_reset, rst |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind start_byte_xor_frame_receiver_core sbx_checker u_sbx_checker (.*);

FILE: sim/tb_start_byte_xor_frame_receiver_core.sv
module tb_start_byte_xor_frame_receiver_core;

  localparam int PAYLOAD_MAX = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  // cycles after the last beat before the block is taken as quiet
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [2:0] {
    RX_HUNT    = 3'b001,
    RX_PAYLOAD = 3'b010,
    RX_CHECK   = 3'b100
  } rx_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] pos;
    logic       last;
  } payload_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] payload_byte;
  logic [4:0] byte_position;
  logic       last_byte;

  // shadow of the block: configuration and frame state
  logic [7:0] shadow_start = sbx_pkg::START_BYTE_RESET;
  logic [5:0] shadow_len   = sbx_pkg::PAYLOAD_LENGTH_RESET;
  rx_phase_t  shadow_phase = RX_HUNT;
  int         shadow_count = 0;
  logic [7:0] shadow_xor   = '0;
  logic [7:0] shadow_store [PAYLOAD_MAX];

  payload_beat_t pending_payload_q[$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  gaps_on = 1'b0;
  int  hold_req = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  int  burst_left = 0;

  start_byte_xor_frame_receiver_core #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .byte_position(byte_position),
    .last_byte    (last_byte)
  );

  always #4 clk = ~clk;

  // 0 is read as 1, anything past the store is clamped
  function automatic int eff_len(input logic [5:0] raw);
    if (raw == 0) return 1;
    if (raw > PAYLOAD_MAX) return PAYLOAD_MAX;
    return int'(raw);
  endfunction

  // one received byte through the deframer shadow
  task automatic frame_decode(input logic [7:0] b);
    int n;
    payload_beat_t beat;
    case (shadow_phase)
      RX_PAYLOAD: begin
        if (shadow_count < PAYLOAD_MAX) begin
          shadow_store[shadow_count] = b;
          shadow_count++;
        end
        shadow_xor ^= b;
        if (shadow_count >= eff_len(shadow_len)) shadow_phase = RX_CHECK;
      end
      RX_CHECK: begin
        if (b == shadow_xor) begin
          n = (shadow_count > sbx_pkg::MAX_RESULTS) ? sbx_pkg::MAX_RESULTS : shadow_count;
          for (int k = 0; k < n; k++) begin
            beat.data = shadow_store[k];
            beat.pos  = 5'(k);
            beat.last = (k + 1 == n);
            pending_payload_q.push_back(beat);
          end
        end
        shadow_phase = RX_HUNT;
      end
      default: begin
        shadow_phase = RX_HUNT;
        if (b == shadow_start) begin
          shadow_phase = RX_PAYLOAD;
          shadow_count = 0;
          shadow_xor   = '0;
        end
      end
    endcase
  endtask

  // accepted register writes and rx beats feed the shadow
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sbx_pkg::REG_START_BYTE) shadow_start = cfg_data;
        else if (cfg_index == sbx_pkg::REG_PAYLOAD_LENGTH) shadow_len = cfg_data[5:0];
      end
      if (in_valid && !in_stall) frame_decode(rx_byte);
    end
  end

  // every payload beat against the oldest expected one
  always @(posedge clk) begin : beat_check
    payload_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_payload_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data=%h pos=%0d last=%b",
                 $time, payload_byte, byte_position, last_byte);
        errors++;
      end else begin
        want = pending_payload_q.pop_front();
        if (want.data !== payload_byte) begin
          $display("%0t: payload_byte expected %h actual %h", $time, want.data, payload_byte);
          errors++;
        end
        if (want.pos !== byte_position) begin
          $display("%0t: byte_position expected %0d actual %0d",
                   $time, want.pos, byte_position);
          errors++;
        end
        if (want.last !== last_byte) begin
          $display("%0t: last_byte expected %b actual %b", $time, want.last, last_byte);
          errors++;
        end
      end
    end
  end

  // receiver side: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one rx beat, held until taken, then maybe a gap
  task automatic send_rx(input logic [7:0] b);
    rx_byte  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // one register write, then the write channel goes quiet
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every expected beat, then let the block settle
  task automatic drain_link();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] sb, input int n, input bit good);
    logic [7:0] x;
    logic [7:0] b;
    x = '0;
    send_rx(sb);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      x ^= b;
      send_rx(b);
    end
    send_rx(good ? x : x ^ 8'($urandom_range(1, 255)));
  endtask

  // reset values: default start byte and 20 byte payload, start byte as data
  task automatic test_reset_values();
    logic [7:0] x;
    logic [7:0] b;
    x = '0;
    send_rx(8'h00);
    send_rx(8'h55);
    send_rx(sbx_pkg::START_BYTE_RESET);
    for (int i = 0; i < 20; i++) begin
      case (i)
        0:       b = sbx_pkg::START_BYTE_RESET;
        1:       b = 8'h00;
        2:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      x ^= b;
      send_rx(b);
    end
    send_rx(x);
    drain_link();
  endtask

  // zero length taken as one, good and bad checksum, lowest start byte
  task automatic test_length_floor();
    write_reg(sbx_pkg::REG_START_BYTE, 8'h00);
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'h00);
    send_frame(8'h00, 1, 1'b1);
    send_frame(8'h00, 1, 1'b0);
    drain_link();
  endtask

  // writes to unused indexes leave both registers alone
  task automatic test_unknown_register();
    write_reg(8'd2, 8'h12);
    write_reg(8'hFF, 8'h3F);
    send_frame(8'h00, 1, 1'b1);
    drain_link();
  endtask

  // payload length moved while a frame is being stored
  task automatic test_length_change_mid_frame();
    write_reg(sbx_pkg::REG_START_BYTE, 8'h5A);
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'd4);
    send_rx(8'h5A);
    send_rx(8'h11);
    send_rx(8'h22);
    drain_link();
    // already past the new length after the next byte
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'd1);
    send_rx(8'h44);
    send_rx(8'h11 ^ 8'h22 ^ 8'h44);
    drain_link();
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'd2);
    send_rx(8'h5A);
    send_rx(8'h81);
    drain_link();
    // longer length stretches the frame
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'd5);
    send_rx(8'h02);
    send_rx(8'h04);
    send_rx(8'h08);
    send_rx(8'h10);
    send_rx(8'h81 ^ 8'h02 ^ 8'h04 ^ 8'h08 ^ 8'h10);
    drain_link();
  endtask

  // receiver holds off while frames keep coming, input backs up
  task automatic test_output_hold_off();
    write_reg(sbx_pkg::REG_START_BYTE, 8'h3C);
    write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, 8'd6);
    hold_req <= hold_req + 1;
    repeat (5) send_frame(8'h3C, 6, 1'b1);
    drain_link();
  endtask

  // random settings, mostly well-formed frames, some bad or broken
  task automatic test_random_traffic(input int target);
    logic [7:0] sb;
    logic [7:0] b;
    logic [5:0] raw;
    int n;
    int frames;
    int r;
    int cut;
    int phase_no;
    phase_no = 0;
    while (items_sent < target) begin
      drain_link();
      sb = (phase_no == 0) ? 8'hFF : 8'($urandom);
      r  = $urandom_range(0, 99);
      if (phase_no == 0) raw = 6'd63;
      else if (r < 65) raw = 6'($urandom_range(1, 8));
      else if (r < 75) raw = 6'd0;
      else if (r < 88) raw = 6'($urandom_range(9, 31));
      else raw = 6'($urandom_range(32, 63));
      if ($urandom_range(0, 5) == 0) write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      write_reg(sbx_pkg::REG_START_BYTE, sb);
      write_reg(sbx_pkg::REG_PAYLOAD_LENGTH, {2'($urandom), raw});
      n = eff_len(raw);
      frames = (n > 16) ? 1 : $urandom_range(2, 6);
      for (int k = 0; k < frames; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(sb, n, 1'b1);
        end else if (r < 85) begin
          send_frame(sb, n, 1'b0);
        end else if (r < 92) begin
          // cut short: the next frame lands inside this payload
          cut = $urandom_range(0, n - 1);
          send_rx(sb);
          repeat (cut) send_rx(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == sb) b = ~b;
            send_rx(b);
          end
        end
      end
      phase_no++;
    end
    drain_link();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gaps_on <= 1'b1;
    test_reset_values();
    test_length_floor();
    test_unknown_register();
    test_length_change_mid_frame();
    test_output_hold_off();
    test_random_traffic(items_sent + 80);

    // closing stretch at full rate on both sides
    gaps_on <= 1'b0;
    test_random_traffic(items_sent + 30);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_payload_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, pending_payload_q.size());
      errors++;
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
